>>> rtl/core/seconds_count_to_calendar_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef SECONDS_COUNT_TO_CALENDAR_ASSERT_SVH
`define SECONDS_COUNT_TO_CALENDAR_ASSERT_SVH

// Concurrent assertion that is switched off while reset is held.
`define SCTC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sctc assertion failed");

// Concurrent assertion that is also checked while reset is held.
`define SCTC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sctc reset assertion failed");

`endif

>>> rtl/core/sctc_pkg.sv
`default_nettype none

package sctc_pkg;

  // Seconds per day is 2^7 * 675: the low bits pass through, the odd part is divided.
  localparam int          DAY_SHIFT   = 7;
  localparam logic [9:0]  DAY_ODD     = 10'd675;
  localparam int          SH_DAY      = 35;
  localparam logic [25:0] RCP_DAY     =
    26'(((64'd1 << SH_DAY) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

  // Days in a four-year cycle, leap year first.
  localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
  localparam int          SH_CYC      = 27;
  localparam logic [16:0] RCP_CYC     =
    17'(((64'd1 << SH_CYC) + 64'(CYCLE_DAYS) - 64'd1) / 64'(CYCLE_DAYS));

  localparam logic [2:0]  WEEK_DAYS   = 3'd7;
  localparam logic [16:0] BASE_WDAY   = 17'd2;
  localparam int          SH_WEEK     = 20;
  localparam logic [17:0] RCP_WEEK    =
    18'(((64'd1 << SH_WEEK) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));

  localparam logic [11:0] HOUR_SECS   = 12'd3600;
  localparam int          SH_HOUR     = 29;
  localparam logic [17:0] RCP_HOUR    =
    18'(((64'd1 << SH_HOUR) + 64'(HOUR_SECS) - 64'd1) / 64'(HOUR_SECS));

  localparam logic [5:0]  MIN_SECS    = 6'd60;
  localparam int          SH_MIN      = 18;
  localparam logic [12:0] RCP_MIN     =
    13'(((64'd1 << SH_MIN) + 64'(MIN_SECS) - 64'd1) / 64'(MIN_SECS));

  localparam logic [10:0] LEAP_DAYS   = 11'd366;
  localparam logic [10:0] COMMON_DAYS = 11'd365;
  localparam logic [11:0] BASE_YEAR   = 12'd1980;

  typedef struct packed {
    logic [15:0] days;
    logic [16:0] sod;
  } sctc_split_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [2:0]  weekday;
  } sctc_date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } sctc_time_t;

  // Day of year at which month idx+1 starts; idx 12 gives the year length.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    begin
      unique case (idx)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        4'd12:   base = 9'd365;
        default: base = 9'd0;
      endcase
      if (leap && (idx >= 4'd2)) begin
        base = base + 9'd1;
      end
      month_start = base;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sctc_day_split.sv
`default_nettype none

// Splits the seconds count into whole days and second of day over two stages.
module sctc_day_split
  import sctc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [31:0] count,
  output sctc_split_t      split
);

  logic [24:0] odd_nxt;
  logic [50:0] prod_nxt;
  logic [50:0] prod_r;
  logic [24:0] odd_r;
  logic [6:0]  low_r;
  logic [15:0] days_nxt;
  logic [25:0] back;
  logic [24:0] rem_full;
  sctc_split_t split_r;

  assign odd_nxt  = count[31:DAY_SHIFT];
  assign prod_nxt = {26'd0, odd_nxt} * {25'd0, RCP_DAY};

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      odd_r  <= odd_nxt;
      low_r  <= count[DAY_SHIFT-1:0];
    end
  end

  assign days_nxt = prod_r[SH_DAY+15:SH_DAY];
  assign back     = {10'd0, days_nxt} * {16'd0, DAY_ODD};
  assign rem_full = odd_r - back[24:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      split_r.days <= days_nxt;
      split_r.sod  <= {rem_full[9:0], low_r};
    end
  end

  assign split = split_r;

endmodule

`default_nettype wire

>>> rtl/core/sctc_date.sv
`default_nettype none

// Day number to year, month, day of month and weekday, stages three to six.
module sctc_date
  import sctc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire sctc_split_t split,
  output sctc_date_t       date
);

  logic [16:0] wdx_nxt;
  logic [32:0] cyc_prod_r;
  logic [34:0] wk_prod_r;
  logic [15:0] days3_r;
  logic [16:0] wdx3_r;

  logic [5:0]  cyc_nxt;
  logic [16:0] cyc_back;
  logic [14:0] wq_nxt;
  logic [17:0] wk_back;
  logic [15:0] dic_full;
  logic [16:0] wk_full;
  logic [5:0]  cyc4_r;
  logic [10:0] dic4_r;
  logic [2:0]  wk4_r;

  logic [1:0]  yic_nxt;
  logic [10:0] ybase;
  logic [10:0] doy_full;
  logic [5:0]  cyc5_r;
  logic [1:0]  yic5_r;
  logic [8:0]  doy5_r;
  logic        leap5_r;
  logic [2:0]  wk5_r;

  logic [3:0]  month_nxt;
  logic [8:0]  mstart;
  logic [8:0]  dom_full;
  sctc_date_t  date_r;

  // Stage three: reciprocal products for the cycle and the week.
  assign wdx_nxt = {1'b0, split.days} + BASE_WDAY;

  always_ff @(posedge clk) begin
    if (adv) begin
      cyc_prod_r <= {17'd0, split.days} * {16'd0, RCP_CYC};
      wk_prod_r  <= {18'd0, wdx_nxt} * {17'd0, RCP_WEEK};
      days3_r    <= split.days;
      wdx3_r     <= wdx_nxt;
    end
  end

  // Stage four: quotients and remainders.
  assign cyc_nxt  = cyc_prod_r[SH_CYC+5:SH_CYC];
  assign cyc_back = {11'd0, cyc_nxt} * {6'd0, CYCLE_DAYS};
  assign dic_full = days3_r - cyc_back[15:0];
  assign wq_nxt   = wk_prod_r[SH_WEEK+14:SH_WEEK];
  assign wk_back  = {3'd0, wq_nxt} * {15'd0, WEEK_DAYS};
  assign wk_full  = wdx3_r - wk_back[16:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      cyc4_r <= cyc_nxt;
      dic4_r <= dic_full[10:0];
      wk4_r  <= wk_full[2:0];
    end
  end

  // Stage five: year within the cycle; only its first year is leap.
  always_comb begin
    priority if (dic4_r < LEAP_DAYS) begin
      yic_nxt = 2'd0;
      ybase   = 11'd0;
    end else if (dic4_r < (LEAP_DAYS + COMMON_DAYS)) begin
      yic_nxt = 2'd1;
      ybase   = LEAP_DAYS;
    end else if (dic4_r < (LEAP_DAYS + COMMON_DAYS + COMMON_DAYS)) begin
      yic_nxt = 2'd2;
      ybase   = LEAP_DAYS + COMMON_DAYS;
    end else begin
      yic_nxt = 2'd3;
      ybase   = LEAP_DAYS + COMMON_DAYS + COMMON_DAYS;
    end
  end

  assign doy_full = dic4_r - ybase;

  always_ff @(posedge clk) begin
    if (adv) begin
      cyc5_r  <= cyc4_r;
      yic5_r  <= yic_nxt;
      doy5_r  <= doy_full[8:0];
      leap5_r <= (yic_nxt == 2'd0);
      wk5_r   <= wk4_r;
    end
  end

  // Stage six: month search against the start-of-month table.
  always_comb begin
    month_nxt = 4'd12;
    for (int m = 12; m >= 1; m--) begin
      if (doy5_r < month_start(leap5_r, 4'(m))) begin
        month_nxt = 4'(m);
      end
    end
  end

  assign mstart   = month_start(leap5_r, month_nxt - 4'd1);
  assign dom_full = doy5_r - mstart + 9'd1;

  always_ff @(posedge clk) begin
    if (adv) begin
      date_r.year    <= BASE_YEAR + {4'd0, cyc5_r, 2'b00} + {10'd0, yic5_r};
      date_r.month   <= month_nxt;
      date_r.dom     <= dom_full[4:0];
      date_r.weekday <= wk5_r;
    end
  end

  assign date = date_r;

endmodule

`default_nettype wire

>>> rtl/core/sctc_clock.sv
`default_nettype none

// Second of day to hour, minute and second, stages three to six.
module sctc_clock
  import sctc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire sctc_split_t split,
  output sctc_time_t       tod
);

  logic [34:0] hprod_r;
  logic [16:0] sod3_r;
  logic [4:0]  hour_nxt;
  logic [16:0] hback;
  logic [16:0] remh_full;
  logic [4:0]  hour4_r;
  logic [11:0] remh4_r;
  logic [24:0] mprod_r;
  logic [4:0]  hour5_r;
  logic [11:0] remh5_r;
  logic [5:0]  min_nxt;
  logic [11:0] mback;
  logic [11:0] sec_full;
  sctc_time_t  tod_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      hprod_r <= {18'd0, split.sod} * {17'd0, RCP_HOUR};
      sod3_r  <= split.sod;
    end
  end

  // The hour never exceeds 23, so five quotient bits suffice.
  assign hour_nxt  = hprod_r[SH_HOUR+4:SH_HOUR];
  assign hback     = {12'd0, hour_nxt} * {5'd0, HOUR_SECS};
  assign remh_full = sod3_r - hback;

  always_ff @(posedge clk) begin
    if (adv) begin
      hour4_r <= hour_nxt;
      remh4_r <= remh_full[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mprod_r <= {13'd0, remh4_r} * {12'd0, RCP_MIN};
      hour5_r <= hour4_r;
      remh5_r <= remh4_r;
    end
  end

  assign min_nxt  = mprod_r[SH_MIN+5:SH_MIN];
  assign mback    = {6'd0, min_nxt} * {6'd0, MIN_SECS};
  assign sec_full = remh5_r - mback;

  always_ff @(posedge clk) begin
    if (adv) begin
      tod_r.hour   <= hour5_r;
      tod_r.minute <= min_nxt;
      tod_r.second <= sec_full[5:0];
    end
  end

  assign tod = tod_r;

endmodule

`default_nettype wire

>>> rtl/core/seconds_count_to_calendar.sv
// Channel   Dir  Signals                          Word contents
// in_       in   in_tvalid in_tready in_tdata     seconds_count[31:0]
// out_      out  out_tvalid out_tready out_tdata  year..weekday, 41 bits in 48
//
// A word is taken every cycle in which adv is high; six register stages, the first
// loaded at the accepting edge, carry its result to out_.
// The six stage registers share one advance enable, set by the output register being
// empty or out_tready high, so one word per cycle is sustained while out_ is ready.
// Reset (rst_n low at a clock edge) clears only the stage valid bits.
// A stall freezes every stage in place, so no word is lost or repeated.
`default_nettype none

module seconds_count_to_calendar
  import sctc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // seconds_count[31:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // year[11:0], month[15:12], day_of_month[20:16],
                                       // hour[25:21], minute[31:26], second[37:32],
                                       // weekday[40:38], zero pad[47:41]
);

  logic        adv;
  logic [5:0]  vld_r;
  logic [5:0]  vld_nxt;
  sctc_split_t split;
  sctc_date_t  date;
  sctc_time_t  tod;

  // The whole pipeline moves when the last stage is free or being drained.
  assign adv       = !vld_r[5] || out_tready;
  assign in_tready = adv;
  assign vld_nxt   = {vld_r[4:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Stages one and two: days and second of day.
  sctc_day_split u_split (
    .clk   (clk),
    .adv   (adv),
    .count (in_tdata),
    .split (split)
  );

  // Stages three to six: the calendar date and the weekday.
  sctc_date u_date (
    .clk   (clk),
    .adv   (adv),
    .split (split),
    .date  (date)
  );

  // Stages three to six, in parallel: the time of day.
  sctc_clock u_clock (
    .clk   (clk),
    .adv   (adv),
    .split (split),
    .tod   (tod)
  );

  assign out_tvalid = vld_r[5];
  assign out_tdata  = {7'd0, date.weekday, tod.second, tod.minute, tod.hour,
                       date.dom, date.month, date.year};

endmodule

`default_nettype wire

>>> rtl/core/sctc_checker.sv
`default_nettype none

`include "seconds_count_to_calendar_assert.svh"

// Port-level checks on the converter.
module sctc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  logic in_seen;

  assign in_seen = in_tvalid && (in_tdata == in_tdata);

  // A waiting result holds until taken.
  `SCTC_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // Input is ready exactly when the pipeline can advance.
  `SCTC_ASSERT(a_ready_adv, clk, rst_n, (in_seen || !in_tvalid) |-> (in_tready == (!out_tvalid || out_tready)))

  // Every delivered field lies in its calendar range.
  `SCTC_ASSERT(a_ranges, clk, rst_n, out_tvalid |-> (out_tdata[11:0] >= 12'd1980) && (out_tdata[15:12] >= 4'd1) && (out_tdata[15:12] <= 4'd12) && (out_tdata[20:16] >= 5'd1) && (out_tdata[25:21] <= 5'd23) && (out_tdata[31:26] <= 6'd59) && (out_tdata[37:32] <= 6'd59) && (out_tdata[40:38] <= 3'd6) && (out_tdata[47:41] == 7'd0))

  // Reset empties the pipeline.
  `SCTC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid)

endmodule

bind seconds_count_to_calendar sctc_checker u_sctc_checker (.*);

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Calendar arithmetic. A four-year cycle starts with its leap year, and every
  // fourth year is leap with no century rule, so 2100 gets a February 29.
  localparam int unsigned DAY_SECS          = 86400;
  localparam int unsigned HOUR_SECS         = 3600;
  localparam int unsigned MINUTE_SECS       = 60;
  localparam int unsigned LEAP_YEAR_SECS    = 366 * DAY_SECS;
  localparam int unsigned COMMON_YEAR_SECS  = 365 * DAY_SECS;
  localparam int unsigned CYCLE_SECS        = LEAP_YEAR_SECS + 3 * COMMON_YEAR_SECS;
  localparam int unsigned EPOCH_YEAR        = 1980;
  localparam int unsigned DAYS_PER_WEEK     = 7;
  localparam int unsigned LAST_CYCLE        = 34;
  localparam int unsigned LAST_DAY          = 49710;

  // Weekday codes as the block reports them; the epoch falls on a Tuesday.
  localparam logic [2:0] SUNDAY    = 3'd0;
  localparam logic [2:0] TUESDAY   = 3'd2;
  localparam logic [2:0] WEDNESDAY = 3'd3;
  localparam logic [2:0] THURSDAY  = 3'd4;
  localparam logic [2:0] FRIDAY    = 3'd5;
  localparam logic [2:0] SATURDAY  = 3'd6;

  // Run shape. The receiver blocks its output for HOLD_CYCLES starting at
  // cycle HOLD_START, early enough to land inside the random part.
  localparam int unsigned RANDOM_WORDS = 1525;
  localparam int unsigned HOLD_START   = 600;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } calendar_t;

  // One row of the directed stimulus. Where known is set, the expected date is
  // written into the row; the other rows are checked against the predictor.
  typedef struct packed {
    logic [31:0] secs;
    logic        known;
    calendar_t   cal;
  } directed_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = 32'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  calendar_t   expected_dates [$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  bit          long_hold      = 1'b0;

  // Directed words: first seconds of each time unit, the leap day of 1980, the
  // ends of a leap year, a common year and a whole cycle, the leap day that the
  // simple rule gives to 2100, and the corners of the 32-bit count.
  directed_row_t directed_rows [25] = '{
    '{32'd0,          1'b1, '{12'd1980, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  TUESDAY}},
    '{32'd59,         1'b1, '{12'd1980, 4'd1,  5'd1,  5'd0,  6'd0,  6'd59, TUESDAY}},
    '{32'd60,         1'b1, '{12'd1980, 4'd1,  5'd1,  5'd0,  6'd1,  6'd0,  TUESDAY}},
    '{32'd3599,       1'b1, '{12'd1980, 4'd1,  5'd1,  5'd0,  6'd59, 6'd59, TUESDAY}},
    '{32'd3600,       1'b1, '{12'd1980, 4'd1,  5'd1,  5'd1,  6'd0,  6'd0,  TUESDAY}},
    '{32'd86399,      1'b1, '{12'd1980, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59, TUESDAY}},
    '{32'd86400,      1'b1, '{12'd1980, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0,  WEDNESDAY}},
    '{32'd5097600,    1'b1, '{12'd1980, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  FRIDAY}},
    '{32'd5184000,    1'b1, '{12'd1980, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  SATURDAY}},
    '{32'd31622399,   1'b1, '{12'd1980, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, WEDNESDAY}},
    '{32'd31622400,   1'b1, '{12'd1981, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  THURSDAY}},
    '{32'd126230399,  1'b1, '{12'd1983, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, SATURDAY}},
    '{32'd126230400,  1'b1, '{12'd1984, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  SUNDAY}},
    '{32'd28944000,   1'b0, '0},
    '{32'd36719999,   1'b0, '0},
    '{32'd36720000,   1'b0, '0},
    '{32'd3786912000, 1'b0, '0},
    '{32'd3792009599, 1'b0, '0},
    '{32'd3792009600, 1'b0, '0},
    '{32'd3792096000, 1'b0, '0},
    '{32'h7FFF_FFFF,  1'b0, '0},
    '{32'h8000_0000,  1'b0, '0},
    '{32'h5555_5555,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'hFFFF_FFFF,  1'b0, '0}
  };

  seconds_count_to_calendar dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned month_length(input int unsigned month, input logic leap);
    case (month)
      2:          return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  // Expected calendar date of a seconds count. The year comes from the cycle
  // and the year within it; the month is found by walking month lengths down
  // from the day of the year.
  function automatic calendar_t seconds_to_calendar(input logic [31:0] secs);
    calendar_t   cal;
    int unsigned rest;
    int unsigned year_in_cycle;
    int unsigned day_of_year;
    int unsigned time_of_day;
    int unsigned month;
    logic        leap;
    rest          = secs % CYCLE_SECS;
    leap          = rest < LEAP_YEAR_SECS;
    year_in_cycle = 0;
    if (!leap) begin
      rest          = rest - LEAP_YEAR_SECS;
      year_in_cycle = 1 + rest / COMMON_YEAR_SECS;
      rest          = rest % COMMON_YEAR_SECS;
    end
    day_of_year = rest / DAY_SECS;
    time_of_day = rest % DAY_SECS;
    month       = 1;
    while (month < 12 && day_of_year >= month_length(month, leap)) begin
      day_of_year = day_of_year - month_length(month, leap);
      month++;
    end
    cal.year         = 12'(EPOCH_YEAR + 4 * (secs / CYCLE_SECS) + year_in_cycle);
    cal.month        = 4'(month);
    cal.day_of_month = 5'(day_of_year + 1);
    cal.hour         = 5'(time_of_day / HOUR_SECS);
    cal.minute       = 6'((time_of_day % HOUR_SECS) / MINUTE_SECS);
    cal.second       = 6'(time_of_day % MINUTE_SECS);
    cal.weekday      = 3'((secs / DAY_SECS + TUESDAY) % DAYS_PER_WEEK);
    return cal;
  endfunction

  // Random seconds count. Four words in ten are uniform over the whole range; the
  // rest sit within two seconds of a month start (with random cycle, year and
  // month) or on a random day with a minute or hour roll-over.
  function automatic logic [31:0] pick_seconds();
    longint unsigned count;
    int unsigned     year_in_cycle;
    int unsigned     month;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6: begin
        count         = longint'($urandom_range(0, LAST_CYCLE)) * CYCLE_SECS;
        year_in_cycle = $urandom_range(0, 3);
        if (year_in_cycle != 0) begin
          count += LEAP_YEAR_SECS + (year_in_cycle - 1) * COMMON_YEAR_SECS;
        end
        month = $urandom_range(1, 12);
        for (int m = 1; m < month; m++) begin
          count += month_length(m, year_in_cycle == 0) * DAY_SECS;
        end
        // Below zero this wraps far past the range and falls back to uniform.
        count = count + $urandom_range(0, 4) - 2;
      end
      default: begin
        count = longint'($urandom_range(0, LAST_DAY)) * DAY_SECS
              + $urandom_range(0, 23) * HOUR_SECS
              + $urandom_range(0, 59) * MINUTE_SECS
              + ($urandom_range(0, 1) ? 59 : 0);
      end
    endcase
    if (count > 64'hFFFF_FFFF) begin
      return $urandom();
    end
    return count[31:0];
  endfunction

  // Offers one word from the falling edge on and holds it until a rising edge
  // sees in_tready high. The expected date is queued at that same edge.
  task automatic send_word(input logic [31:0] secs, input calendar_t want);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    do @(posedge clk); while (in_tready !== 1'b1);
    expected_dates.push_back(want);
  endtask

  // Sender pacing: bursts of random length, now and then a long one, with a
  // random gap (sometimes none) in front of each. While the receiver holds off
  // the sender never pauses, so the pipeline fills and stalls its input.
  task automatic pace_sender();
    int unsigned gap;
    if (long_hold) begin
      return;
    end
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: out_tready follows a 16-bit ready pattern, indexed by the cycle
  // count and redrawn at random. Some windows are fully ready, some sparse; one
  // long hold-off is counted here so the sender sees backpressure reach its input.
  initial begin : receiver
    int unsigned cycle_count;
    logic [15:0] ready_pattern;
    cycle_count   = 0;
    ready_pattern = 16'hFFFF;
    forever begin
      @(negedge clk);
      cycle_count++;
      if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_CYCLES) begin
        long_hold = 1'b1;
        out_tready <= 1'b0;
      end else begin
        long_hold = 1'b0;
        if (cycle_count % 64 == 0) begin
          case ($urandom_range(0, 3))
            0:       ready_pattern = 16'hFFFF;
            1:       ready_pattern = 16'($urandom() & $urandom()) | 16'h0001;
            default: ready_pattern = 16'($urandom()) | 16'h0001;
          endcase
        end
        out_tready <= ready_pattern[cycle_count % 16];
      end
    end
  end

  // Every result word taken at a rising edge is unpacked and compared with the
  // oldest pending date. Fields sit in out_tdata from bit 0 upward.
  always @(posedge clk) begin : check_results
    calendar_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (expected_dates.size() == 0) begin
        $error("result word %h arrived with no date pending", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("year",         want.year,         out_tdata[11:0]);
        check_field("month",        want.month,        out_tdata[15:12]);
        check_field("day_of_month", want.day_of_month, out_tdata[20:16]);
        check_field("hour",         want.hour,         out_tdata[25:21]);
        check_field("minute",       want.minute,       out_tdata[31:26]);
        check_field("second",       want.second,       out_tdata[37:32]);
        check_field("weekday",      want.weekday,      out_tdata[40:38]);
        check_field("zero pad",     0,                 out_tdata[47:41]);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] secs;
    // Synchronous reset, held low from time zero and released at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      pace_sender();
      send_word(directed_rows[i].secs,
                directed_rows[i].known ? directed_rows[i].cal
                                       : seconds_to_calendar(directed_rows[i].secs));
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Halfway through, the sender goes quiet until every result is back.
      if (i == RANDOM_WORDS / 2) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (expected_dates.size() != 0) @(negedge clk);
      end
      pace_sender();
      secs = pick_seconds();
      send_word(secs, seconds_to_calendar(secs));
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    // A further wait to catch any stray result word.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
